@@ sv/xsp_pkg.sv @@
// ---------------------------------------------------------------------------
// xsp_pkg
// shared types and constants of the scrambled 512-bit xorshift generator
// ---------------------------------------------------------------------------
package xsp_pkg;

    localparam int WORD_W     = 64;
    localparam int WORD_COUNT = 8;
    localparam int IDX_W      = 3;
    localparam int HALF_W     = WORD_W / 2;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    localparam logic [WORD_W-1:0] SCRAMBLE_MUL    = 64'd6906969069;
    localparam logic [HALF_W-1:0] SCRAMBLE_MUL_LO = SCRAMBLE_MUL[HALF_W-1:0];
    localparam logic [HALF_W-1:0] SCRAMBLE_MUL_HI = SCRAMBLE_MUL[WORD_W-1:HALF_W];
    localparam logic [WORD_W-1:0] SCRAMBLE_OR     = 64'h0000_0000_4000_0005;
    localparam logic [WORD_W-1:0] ZERO_SEED_SUBST = 64'h0123_4567_89AB_CDEF;

    localparam int SCRAMBLE_ROT = 11;
    localparam int SHIFT_A      = 15;
    localparam int ROT_B        = 27;
    localparam int ROT_C        = 46;

    typedef enum logic [0:0] {
        OP_NEXT = 1'b0,
        OP_LOAD = 1'b1
    } xsp_op_t;

    typedef logic [WORD_W-1:0] xsp_word_t;

    // one word moving between front, queue and back
    typedef struct packed {
        logic      valid;
        xsp_word_t word;
    } xsp_xfer_t;

    function automatic xsp_word_t rotl(input xsp_word_t v, input int k);
        xsp_word_t res;
        res = (v << k) | (v >> (WORD_W - k));
        return res;
    endfunction

endpackage

@@ sv/xsp_req_if.sv @@
// ---------------------------------------------------------------------------
// xsp_req_if
// request channel: one next or seed load item per handshake
// ---------------------------------------------------------------------------
interface xsp_req_if import xsp_pkg::*;;

    logic                   valid;
    logic                   ready;
    xsp_op_t                operation;
    logic [IDX_W-1:0]       seed_index;
    logic [WORD_W-1:0]      seed_value;

    modport source (output valid, output operation, output seed_index,
                    output seed_value, input ready);
    modport sink   (input valid, input operation, input seed_index,
                    input seed_value, output ready);

endinterface

@@ sv/xsp_rsp_if.sv @@
// ---------------------------------------------------------------------------
// xsp_rsp_if
// response channel: one random value per handshake
// ---------------------------------------------------------------------------
interface xsp_rsp_if import xsp_pkg::*;;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] random_value;

    modport source (output valid, output random_value, input ready);
    modport sink   (input valid, input random_value, output ready);

endinterface

@@ sv/xsp_front.sv @@
// ---------------------------------------------------------------------------
// xsp_front
// holds the eight state words, takes items, applies loads and state steps,
// and hands the old word 0 of each next item to the queue
// ---------------------------------------------------------------------------
module xsp_front import xsp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    xsp_req_if.sink   req,
    input  logic      queue_full,
    output xsp_xfer_t push
);

    xsp_word_t state_reg  [WORD_COUNT];
    xsp_word_t state_next [WORD_COUNT];
    logic      accept;

    assign req.ready = !queue_full;
    assign accept    = req.valid && req.ready;

    assign push.valid = accept && (req.operation == OP_NEXT);
    assign push.word  = state_reg[0];

    always_comb
    begin
        xsp_word_t x0;
        xsp_word_t x7;
        xsp_word_t w6;
        x0 = state_reg[0];
        x7 = state_reg[WORD_COUNT-1];
        w6 = x0 ^ x7;
        for (int i = 0; i < WORD_COUNT; i++)
        begin
            state_next[i] = state_reg[i];
        end
        if (accept)
        begin
            case (req.operation)
                OP_LOAD:
                begin
                    if (req.seed_index == '0 && req.seed_value == '0)
                    begin
                        state_next[0] = ZERO_SEED_SUBST;
                    end
                    else
                    begin
                        state_next[req.seed_index] = req.seed_value;
                    end
                end
                OP_NEXT:
                begin
                    state_next[0] = x0 ^ state_reg[1];
                    for (int i = 1; i < WORD_COUNT - 2; i++)
                    begin
                        state_next[i] = state_reg[i+1];
                    end
                    state_next[WORD_COUNT-2] = w6;
                    state_next[WORD_COUNT-1] = (x0 << SHIFT_A) ^ w6
                                             ^ rotl(x7, ROT_B) ^ rotl(x7, ROT_C);
                end
                default:
                begin
                    state_next[0] = state_reg[0];
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WORD_COUNT; i++)
            begin
                state_reg[i] <= '0;
            end
            state_reg[0] <= ZERO_SEED_SUBST;
        end
        else
        begin
            for (int i = 0; i < WORD_COUNT; i++)
            begin
                state_reg[i] <= state_next[i];
            end
        end
    end

endmodule

@@ sv/xsp_queue.sv @@
// ---------------------------------------------------------------------------
// xsp_queue
// short first-in first-out queue of words between front and back
// ---------------------------------------------------------------------------
module xsp_queue import xsp_pkg::*;
#(
    parameter int Depth = QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  xsp_xfer_t push,
    output logic      full,
    output xsp_xfer_t head,
    input  logic      pop
);

    localparam int PtrW = $clog2(Depth);
    localparam int CntW = $clog2(Depth + 1);

    xsp_word_t       mem_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;
    logic            do_push;
    logic            do_pop;

    assign full       = (count_reg == CntW'(Depth));
    assign head.valid = (count_reg != '0);
    assign head.word  = mem_reg[rd_ptr_reg];

    assign do_push = push.valid && !full;
    assign do_pop  = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.word;
        end
    end

endmodule

@@ sv/xsp_back.sv @@
// ---------------------------------------------------------------------------
// xsp_back
// five-stage scrambler pipeline: two split 64-bit multiplies, rotate, add
// ---------------------------------------------------------------------------
module xsp_back import xsp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  xsp_xfer_t head,
    output logic      pop,
    xsp_rsp_if.source rsp
);

    logic              v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic              advance;

    // stage 1: partial products of x0 * multiplier
    logic [WORD_W-1:0] m_ll_reg;
    logic [HALF_W-1:0] m_hl_reg;
    logic [HALF_W-1:0] m_lh_reg;
    // stage 2: r
    xsp_word_t         r2_reg;
    // stage 3: partial products of r * r
    logic [WORD_W-1:0] s_ll_reg;
    logic [HALF_W-1:0] s_lh_reg;
    xsp_word_t         r3_reg;
    // stage 4: r * r
    xsp_word_t         sq_reg;
    xsp_word_t         r4_reg;
    // stage 5: output register
    xsp_word_t         out_reg;

    logic [HALF_W-1:0] x_lo;
    logic [HALF_W-1:0] x_hi;
    logic [HALF_W-1:0] m_cross;
    xsp_word_t         prod;
    logic [HALF_W-1:0] r_lo;
    logic [HALF_W-1:0] r_hi;

    assign advance = !v5_reg || rsp.ready;
    assign pop     = advance && head.valid;

    assign rsp.valid        = v5_reg;
    assign rsp.random_value = out_reg;

    assign x_lo    = head.word[HALF_W-1:0];
    assign x_hi    = head.word[WORD_W-1:HALF_W];
    assign m_cross = m_hl_reg + m_lh_reg;
    assign prod    = m_ll_reg + {m_cross, {HALF_W{1'b0}}};
    assign r_lo    = r2_reg[HALF_W-1:0];
    assign r_hi    = r2_reg[WORD_W-1:HALF_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= pop;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m_ll_reg <= x_lo * SCRAMBLE_MUL_LO;
            m_hl_reg <= x_hi * SCRAMBLE_MUL_LO;
            m_lh_reg <= x_lo * SCRAMBLE_MUL_HI;

            r2_reg   <= rotl(prod, SCRAMBLE_ROT);

            // low half of r * r: lo*lo plus twice lo*hi shifted up
            s_ll_reg <= r_lo * r_lo;
            s_lh_reg <= r_lo * r_hi;
            r3_reg   <= r2_reg;

            sq_reg   <= s_ll_reg + {s_lh_reg[HALF_W-2:0], {(HALF_W+1){1'b0}}};
            r4_reg   <= r3_reg;

            out_reg  <= r4_reg + (sq_reg | SCRAMBLE_OR);
        end
    end

endmodule

@@ sv/xorshift512_scrambled_prng_unit.sv @@
// ---------------------------------------------------------------------------
// xorshift512_scrambled_prng_unit
// scrambled 512-bit xorshift random generator with seed loading
// ---------------------------------------------------------------------------
// The unit takes one item per clock cycle, next or seed load alike, as long
// as the queue between the state front and the scrambler has room; the state
// register set in the front steps once per accepted item, which sets that
// rate. A load writes one state word (a zero for word 0 is stored as
// 0x0123456789ABCDEF) and gives no result. A next item gives one random value
// after it has passed the queue and then a five-stage scrambler pipeline that
// ends in the output register; results come out in item order and one per
// cycle while the sink takes them. A stalled sink lets the pipeline move only
// until its oldest value sits in the output register; the pipeline then
// freezes, bubbles included, and further values collect in the queue
// (QueueDepth words) before the request side stalls.
// ---------------------------------------------------------------------------
module xorshift512_scrambled_prng_unit import xsp_pkg::*;
#(
    parameter int QueueDepth = QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    xsp_req_if.sink   req,
    xsp_rsp_if.source rsp
);

    xsp_xfer_t push;
    xsp_xfer_t head;
    logic      queue_full;
    logic      pop;

    xsp_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .queue_full (queue_full),
        .push       (push)
    );

    xsp_queue #(
        .Depth (QueueDepth)
    ) u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (queue_full),
        .head  (head),
        .pop   (pop)
    );

    xsp_back u_back
    (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .rsp   (rsp)
    );

endmodule
